// ----- design/sgqt_pkg.sv -----
// Shared types and constants for the square grid quarter-turn store.
// Request codes, fixed field widths, controller state and command struct.
`timescale 1ns / 1ps

package sgqt_pkg;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 8;
  localparam int SIDE_W = 7;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 7'd64;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_TURN_A = 2'd2,
    REQ_TURN_B = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ORI_0   = 2'd0,
    ORI_90  = 2'd1,
    ORI_180 = 2'd2,
    ORI_270 = 2'd3
  } orient_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  typedef struct packed {
    logic take;
  } ctl_cmd_t;

endpackage

// ----- design/sgqt_ctrl.sv -----
// Controller for the grid store: tracks whether a result is held and
// issues the take command. Depends on sgqt_pkg.
`timescale 1ns / 1ps

module sgqt_ctrl
  import sgqt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   take;

  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign take      = in_valid && !in_stall;
  assign out_valid = (state_r == ST_HOLD);
  assign cmd.take  = take;

  always_comb begin
    unique case (state_r)
      ST_IDLE: state_nxt = take ? ST_HOLD : ST_IDLE;
      ST_HOLD: state_nxt = (take || out_stall) ? ST_HOLD : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/sgqt_dpath.sv -----
// Datapath for the grid store: side register, orientation, address remap,
// cell memory and result registers. Depends on sgqt_pkg.
`timescale 1ns / 1ps

module sgqt_dpath
  import sgqt_pkg::*;
#(
  parameter int MAX_SIDE  = 64,
  parameter int CELL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  input  logic              cfg_wr_en,
  input  logic [SIDE_W-1:0] cfg_wr_data,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [VAL_W-1:0]  in_cell_value,
  output logic [VAL_W-1:0]  out_read_value,
  output logic              out_out_of_range
);

  localparam int SW    = ($clog2(MAX_SIDE + 1) > SIDE_W) ? $clog2(MAX_SIDE + 1) : SIDE_W;
  localparam int IW    = $clog2(MAX_SIDE);
  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [SIDE_W-1:0]    grid_side_r;
  orient_t              ori_r, ori_nxt;
  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rdata_r;
  logic                 rd_hit_r;
  logic                 oor_r;

  req_t                 req;
  logic [SW-1:0]        side_ext, eff_side, row_ext, col_ext, row_inv, col_inv;
  logic [SW-1:0]        pr_w, pc_w;
  logic [IW-1:0]        pr, pc;
  logic [AW-1:0]        addr;
  logic                 oor, is_access, do_wr, do_rd;
  logic [CELL_BITS+VAL_W-1:0] wr_ext, rd_ext;

  assign req      = req_t'(in_req_type);
  assign side_ext = SW'(grid_side_r);
  assign eff_side = (side_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : side_ext;
  assign row_ext  = SW'(in_row);
  assign col_ext  = SW'(in_col);
  assign row_inv  = eff_side - SW'(1) - row_ext;
  assign col_inv  = eff_side - SW'(1) - col_ext;

  assign is_access = (req == REQ_WRITE) || (req == REQ_READ);
  assign oor       = (row_ext >= eff_side) || (col_ext >= eff_side);
  assign do_wr     = cmd.take && (req == REQ_WRITE) && !oor;
  assign do_rd     = cmd.take && (req == REQ_READ) && !oor;

  always_comb begin
    unique case (ori_r)
      ORI_90: begin
        pr_w = col_inv;
        pc_w = row_ext;
      end
      ORI_180: begin
        pr_w = row_inv;
        pc_w = col_inv;
      end
      ORI_270: begin
        pr_w = col_ext;
        pc_w = row_inv;
      end
      default: begin
        pr_w = row_ext;
        pc_w = col_ext;
      end
    endcase
  end

  assign pr   = pr_w[IW-1:0];
  assign pc   = pc_w[IW-1:0];
  assign addr = AW'(pr) * AW'(MAX_SIDE) + AW'(pc);

  always_comb begin
    unique case (req)
      REQ_TURN_A: ori_nxt = orient_t'(ori_r + 2'd1);
      REQ_TURN_B: ori_nxt = orient_t'(ori_r - 2'd1);
      default:    ori_nxt = ori_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
      ori_r       <= ORI_0;
    end else begin
      if (cfg_wr_en) begin
        grid_side_r <= cfg_wr_data;
      end
      if (cmd.take) begin
        ori_r <= ori_nxt;
      end
    end
  end

  assign wr_ext = {{CELL_BITS{1'b0}}, in_cell_value};

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[addr] <= wr_ext[CELL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (do_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_hit_r <= (req == REQ_READ) && !oor;
      oor_r    <= is_access && oor;
    end
  end

  assign rd_ext           = {{VAL_W{1'b0}}, rdata_r};
  assign out_read_value   = rd_hit_r ? rd_ext[VAL_W-1:0] : '0;
  assign out_out_of_range = oor_r;

endmodule

// ----- design/square_grid_quarter_turn_store.sv -----
// A result is valid the cycle after its request transfer. One request
// per cycle unless stalled; a read or write makes one single-port memory
// access; turns only step a 2-bit orientation that remaps addresses.
// Reset: orientation cleared, grid side set to 64; cell contents stay
// undefined until written, no clearing pass. Depends on sgqt_pkg.
`timescale 1ns / 1ps

module square_grid_quarter_turn_store
  import sgqt_pkg::*;
#(
  parameter int MAX_SIDE  = 64,
  parameter int CELL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIDE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [IDX_W-1:0]  in_row,
  input  logic [IDX_W-1:0]  in_col,
  input  logic [VAL_W-1:0]  in_cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [VAL_W-1:0]  out_read_value,
  output logic              out_out_of_range
);

  ctl_cmd_t cmd;

  sgqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sgqt_dpath #(
    .MAX_SIDE  (MAX_SIDE),
    .CELL_BITS (CELL_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_type      (in_req_type),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_cell_value    (in_cell_value),
    .out_read_value   (out_read_value),
    .out_out_of_range (out_out_of_range)
  );

endmodule

// ----- design/sgqt_checker.sv -----
// Port-level checks for the grid store, bound to the top level.
// Depends on sgqt_pkg.
`timescale 1ns / 1ps

module sgqt_checker
  import sgqt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [REQ_W-1:0]  in_req_type,
  input logic              out_valid,
  input logic              out_stall,
  input logic [VAL_W-1:0]  out_read_value,
  input logic              out_out_of_range
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_out_of_range))
    else $error("result changed while stalled");

  a_turn: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_req_type == REQ_TURN_A || in_req_type == REQ_TURN_B)
      |=> out_valid && out_read_value == '0 && !out_out_of_range)
    else $error("turn result not zero");

  a_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_req_type == REQ_WRITE |=> out_valid && out_read_value == '0)
    else $error("write result carries data");

  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_read_value == '0)
    else $error("out-of-range result carries data");

endmodule

bind square_grid_quarter_turn_store sgqt_checker u_sgqt_checker (.*);
